### design/iuset_pkg.sv
package iuset_pkg;

    localparam int ENTRIES   = 64;
    localparam int ADDR_BITS = 48;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int USED_W = 7;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((2 * ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 + USED_W + 7) / 8) * 8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] lo_addr;
        logic [ADDR_BITS-1:0] hi_addr;
    } t_entry;

endpackage

### design/interval_union_set_top.sv
// Merging interval set. Holds up to 64 disjoint half-open address ranges
// [begin, end), 48-bit addresses, that together form the union of every
// range inserted so far. A request is either an insert (tuser = 0) or a
// membership query (tuser = 1); tdata carries range_begin in bits [47:0]
// and range_end in bits [95:48] (ignored for a query). An insert merges
// every stored range that overlaps it or that starts exactly at its end
// into one range placed in the lowest merged entry; a range ending exactly
// at the new begin stays separate. A new range takes the lowest free entry;
// an insert that merges nothing while the table is full is dropped with
// status 1. An empty or inverted insert changes nothing. Every request gets
// exactly one response: hit, status and the count of stored ranges.
// Flow: a query or a non-empty insert takes the request, walks the range
// store through its single read port one entry per cycle, then writes
// back; an empty insert skips the walk. The response sits in an output
// register, so the next request is taken while it waits; the block only
// stalls at write-back if the previous response is still pending.
module interval_union_set_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request: [47:0] range_begin, [95:48] range_end, rest zero
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [iuset_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // request: [0] req_type
    input  logic                                i_s_tuser,
    // response: [0] hit, [1] status, [8:2] used_count, rest zero
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [iuset_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    import iuset_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           r_state;

    // latched request
    logic                 r_type;
    logic                 r_skip;
    logic [ADDR_BITS-1:0] r_nb;
    logic [ADDR_BITS-1:0] r_ne;

    // scan state
    logic [IDX_W:0]       r_idx;
    logic                 r_cmp_on;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_hit;
    logic                 r_merged;
    logic [IDX_W-1:0]     r_slot;
    logic                 r_have_free;
    logic [IDX_W-1:0]     r_free_slot;
    logic [ADDR_BITS-1:0] r_lo;
    logic [ADDR_BITS-1:0] r_hi;

    // table bookkeeping
    logic [ENTRIES-1:0]   r_valid;
    logic [CNT_W-1:0]     r_count;

    // response register
    logic                 r_out_vld;
    logic                 r_out_hit;
    logic                 r_out_status;
    logic [USED_W-1:0]    r_out_used;

    logic                 in_fire;
    logic                 done_fire;
    logic                 scan_last;
    logic [ADDR_BITS-1:0] in_nb;
    logic [ADDR_BITS-1:0] in_ne;
    logic                 ent_vld;
    logic                 ent_hold;
    logic                 ent_ovl;
    logic                 do_insert;
    logic                 do_alloc;
    logic                 drop_full;
    logic [CNT_W-1:0]     n_count;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    t_entry               wr_data;
    t_entry               rd_data;

    assign in_nb = i_s_tdata[ADDR_BITS-1:0];
    assign in_ne = i_s_tdata[2*ADDR_BITS-1:ADDR_BITS];

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign done_fire  = (r_state == S_DONE) && (!r_out_vld || i_m_tready);
    assign scan_last  = (r_idx == (IDX_W+1)'(ENTRIES));

    iuset_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared compare unit: one stored entry per cycle against the request.
    assign ent_vld  = r_cmp_on && r_valid[r_cmp_idx];
    assign ent_hold = (rd_data.lo_addr <= r_nb) && (r_nb < rd_data.hi_addr);
    assign ent_ovl  = (rd_data.lo_addr <= r_ne) && (rd_data.hi_addr > r_nb);

    // Write-back decision at the end of the walk.
    assign do_insert = (r_type == REQ_INSERT) && !r_skip;
    assign do_alloc  = do_insert && !r_merged && r_have_free;
    assign drop_full = do_insert && !r_merged && !r_have_free;
    assign n_count   = do_alloc ? r_count + CNT_W'(1) : r_count;

    always_comb begin
        wr_en   = done_fire && do_insert && (r_merged || r_have_free);
        wr_addr = r_merged ? r_slot : r_free_slot;
        if (r_merged) begin
            wr_data.lo_addr = r_lo;
            wr_data.hi_addr = r_hi;
        end else begin
            wr_data.lo_addr = r_nb;
            wr_data.hi_addr = r_ne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_cmp_on  <= 1'b0;
        end else begin
            // load a finished request's response, else drop the one taken
            if (done_fire) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_type      <= i_s_tuser;
                        r_nb        <= in_nb;
                        r_ne        <= in_ne;
                        r_lo        <= in_nb;
                        r_hi        <= in_ne;
                        r_hit       <= 1'b0;
                        r_merged    <= 1'b0;
                        r_have_free <= 1'b0;
                        r_idx       <= '0;
                        r_cmp_on    <= 1'b0;
                        // empty or inverted insert: skip the walk
                        if (i_s_tuser == REQ_INSERT && !(in_nb < in_ne)) begin
                            r_skip  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_skip  <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    // advance the read address; compare the entry read last cycle
                    r_cmp_on  <= !scan_last;
                    r_cmp_idx <= r_idx[IDX_W-1:0];
                    if (!scan_last) begin
                        r_idx <= r_idx + (IDX_W+1)'(1);
                    end else begin
                        r_state <= S_DONE;
                    end

                    if (r_type == REQ_QUERY) begin
                        if (ent_vld && ent_hold) begin
                            r_hit <= 1'b1;
                        end
                    end else if (ent_vld) begin
                        if (ent_ovl) begin
                            if (rd_data.lo_addr < r_lo) begin
                                r_lo <= rd_data.lo_addr;
                            end
                            if (rd_data.hi_addr > r_hi) begin
                                r_hi <= rd_data.hi_addr;
                            end
                            if (!r_merged) begin
                                r_merged <= 1'b1;
                                r_slot   <= r_cmp_idx;
                            end else begin
                                // free every merged entry after the first
                                r_valid[r_cmp_idx] <= 1'b0;
                                if (r_count != '0) begin
                                    r_count <= r_count - CNT_W'(1);
                                end
                            end
                        end
                    end else if (r_cmp_on && !r_have_free) begin
                        r_have_free <= 1'b1;
                        r_free_slot <= r_cmp_idx;
                    end
                end

                S_DONE: begin
                    // hold until the response register is free
                    if (done_fire) begin
                        if (do_alloc) begin
                            r_valid[r_free_slot] <= 1'b1;
                        end
                        r_count      <= n_count;
                        r_out_hit    <= (r_type == REQ_QUERY) && r_hit;
                        r_out_status <= drop_full ? STATUS_FULL : STATUS_OK;
                        r_out_used   <= USED_W'(n_count);
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(OUT_DATA_W - 2 - USED_W)'(0), r_out_used, r_out_status, r_out_hit};

endmodule

### design/iuset_store.sv
// Range store: one write port, one read port, registered read data.
module iuset_store (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [iuset_pkg::IDX_W-1:0] i_wr_addr,
    input  iuset_pkg::t_entry           i_wr_data,
    input  logic [iuset_pkg::IDX_W-1:0] i_rd_addr,
    output iuset_pkg::t_entry           o_rd_data
);
    import iuset_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
